/* rtl/slsc_pkg.sv */
// slsc_pkg: shared codes and controller/datapath interface structs for the
// single-line sector cache. No dependencies.
`default_nettype none

package slsc_pkg;

   // sector size in bytes, fixed by the 9-bit in-sector offset and 6-bit word index
   localparam int SECTOR_BYTES = 512;

   // request kinds carried in tuser
   localparam logic [2:0] KIND_READ  = 3'd0;
   localparam logic [2:0] KIND_WRITE = 3'd1;
   localparam logic [2:0] KIND_ZERO  = 3'd2;
   localparam logic [2:0] KIND_FLUSH = 3'd3;
   localparam logic [2:0] KIND_FILL  = 3'd4;
   localparam logic [2:0] KIND_ACK   = 3'd5;

   // result kinds
   localparam logic [1:0] RK_CPL  = 2'd0;
   localparam logic [1:0] RK_WB   = 2'd1;
   localparam logic [1:0] RK_RREQ = 2'd2;

   // completion status
   localparam logic [1:0] ST_GOOD  = 2'd0;
   localparam logic [1:0] ST_WERR  = 2'd1;
   localparam logic [1:0] ST_RERR  = 2'd2;
   localparam logic [1:0] ST_INVAL = 2'd3;

   // pending request codes
   localparam logic [1:0] PREQ_READ  = 2'd0;
   localparam logic [1:0] PREQ_WRITE = 2'd1;
   localparam logic [1:0] PREQ_ZERO  = 2'd2;
   localparam logic [1:0] PREQ_FLUSH = 2'd3;

   // buffer read address select
   localparam logic [1:0] RD_IN   = 2'd0;
   localparam logic [1:0] RD_PEND = 2'd1;
   localparam logic [1:0] RD_WB   = 2'd2;

   // output register source select
   localparam logic [1:0] OUT_CPL   = 2'd0;
   localparam logic [1:0] OUT_RBYTE = 2'd1;
   localparam logic [1:0] OUT_RREQ  = 2'd2;
   localparam logic [1:0] OUT_WB    = 2'd3;

   // stream payload widths
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 112;

   typedef struct packed {
      logic       pend_ld;
      logic [1:0] pend_req;
      logic       pend_sec_ld;
      logic       pend_acc_ld;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       fill_wr;
      logic       fill_clr;
      logic       acc_wr;
      logic       zero_now;
      logic       zero_from_in;
      logic       commit_fill;
      logic       wb_start;
      logic       wb_inc;
      logic       out_ld;
      logic [1:0] out_sel;
      logic [1:0] out_status;
      logic       rreq_from_in;
   } slsc_cmd_type;

   typedef struct packed {
      logic       hit;
      logic       off_ok;
      logic       needs_wb;
      logic       wb_last;
      logic [1:0] pend_req;
   } slsc_sts_type;

endpackage

`default_nettype wire

/* rtl/slsc_dp.sv */
// slsc_dp: datapath of the sector cache - sector buffer memory with valid
// bits, cached sector, dirty flag, pending request and the result register.
// Depends on slsc_pkg.
`default_nettype none

module slsc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  slsc_pkg::slsc_cmd_type cmd,
   output slsc_pkg::slsc_sts_type sts,
   input  logic [31:0]           in_sector,
   input  logic [9:0]            in_offset,
   input  logic [7:0]            in_byte,
   input  logic [63:0]           in_fill,
   output logic [1:0]            out_kind,
   output logic [1:0]            out_status,
   output logic [7:0]            out_rbyte,
   output logic [31:0]           out_sector,
   output logic [63:0]           out_word,
   output logic [5:0]            out_index,
   output logic                  out_last
);
   import slsc_pkg::*;

   localparam int NWORDS = SECTOR_BYTES / 8;
   localparam int AW = $clog2(NWORDS);
   localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);
   localparam logic [12:0] SB_LIMIT = 13'(SECTOR_BYTES);

   logic [63:0]       mem [NWORDS];
   logic [NWORDS-1:0] vld_ff, vld_in;
   logic [31:0]       cached_ff, cached_in;
   logic              dirty_ff, dirty_in;
   logic [1:0]        pend_req_ff, pend_req_in;
   logic [31:0]       pend_sec_ff, pend_sec_in;
   logic [8:0]        pend_off_ff, pend_off_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;
   logic [AW-1:0]     fill_cnt_ff, fill_cnt_in;
   logic [AW-1:0]     wb_cnt_ff, wb_cnt_in;
   logic [63:0]       rd_word_ff;
   logic              rd_vld_ff;

   logic [AW-1:0]     in_waddr, pend_waddr, rd_addr, wr_addr;
   logic              wr_en;
   logic [63:0]       wr_data, rd_word, merged;
   logic [5:0]        sh;
   logic [7:0]        rbyte;

   logic [1:0]        out_kind_ff, out_status_ff;
   logic [7:0]        out_rbyte_ff;
   logic [31:0]       out_sector_ff;
   logic [63:0]       out_word_ff;
   logic [5:0]        out_index_ff;
   logic              out_last_ff;

   // word addresses and byte lane
   assign in_waddr   = AW'(in_offset[8:0] >> 3);
   assign pend_waddr = AW'(pend_off_ff >> 3);
   assign sh         = {pend_off_ff[2:0], 3'b000};
   assign rd_word    = rd_vld_ff ? rd_word_ff : 64'd0;
   assign merged     = (rd_word & ~(64'hFF << sh)) | ({56'd0, pend_byte_ff} << sh);
   assign rbyte      = 8'(rd_word >> sh);

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_IN:   rd_addr = in_waddr;
         RD_PEND: rd_addr = pend_waddr;
         default: rd_addr = wb_cnt_ff;
      endcase
   end

   // write port: fill words or merged byte write
   always_comb begin
      wr_en   = cmd.fill_wr | cmd.acc_wr;
      wr_addr = cmd.fill_wr ? fill_cnt_ff : pend_waddr;
      wr_data = cmd.fill_wr ? in_fill : merged;
   end

   // sector buffer memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_word_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   // next state of the cache tags and pending request
   always_comb begin
      vld_in       = vld_ff;
      cached_in    = cached_ff;
      dirty_in     = dirty_ff;
      pend_req_in  = pend_req_ff;
      pend_sec_in  = pend_sec_ff;
      pend_off_in  = pend_off_ff;
      pend_byte_in = pend_byte_ff;
      fill_cnt_in  = fill_cnt_ff;
      wb_cnt_in    = wb_cnt_ff;
      if (cmd.zero_now) begin
         vld_in    = '0;
         cached_in = cmd.zero_from_in ? in_sector : pend_sec_ff;
         dirty_in  = 1'b1;
      end
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (cmd.commit_fill) begin
         cached_in = pend_sec_ff;
         dirty_in  = 1'b0;
      end
      if (cmd.acc_wr) begin
         dirty_in = 1'b1;
      end
      if (cmd.wb_start) begin
         dirty_in  = 1'b0;
         wb_cnt_in = '0;
      end
      if (cmd.wb_inc) begin
         wb_cnt_in = wb_cnt_ff + 1'b1;
      end
      if (cmd.pend_ld) begin
         pend_req_in = cmd.pend_req;
      end
      if (cmd.pend_sec_ld) begin
         pend_sec_in = in_sector;
      end
      if (cmd.pend_acc_ld) begin
         pend_off_in  = in_offset[8:0];
         pend_byte_in = in_byte;
      end
      if (cmd.fill_clr) begin
         fill_cnt_in = '0;
      end else if (cmd.fill_wr) begin
         fill_cnt_in = (fill_cnt_ff == LAST_WORD) ? '0 : fill_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         cached_ff    <= '0;
         dirty_ff     <= 1'b0;
         pend_req_ff  <= PREQ_READ;
         pend_sec_ff  <= '0;
         pend_off_ff  <= '0;
         pend_byte_ff <= '0;
         fill_cnt_ff  <= '0;
         wb_cnt_ff    <= '0;
      end else begin
         vld_ff       <= vld_in;
         cached_ff    <= cached_in;
         dirty_ff     <= dirty_in;
         pend_req_ff  <= pend_req_in;
         pend_sec_ff  <= pend_sec_in;
         pend_off_ff  <= pend_off_in;
         pend_byte_ff <= pend_byte_in;
         fill_cnt_ff  <= fill_cnt_in;
         wb_cnt_ff    <= wb_cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         out_kind_ff   <= RK_CPL;
         out_status_ff <= ST_GOOD;
         out_rbyte_ff  <= 8'd0;
         out_sector_ff <= 32'd0;
         out_word_ff   <= 64'd0;
         out_index_ff  <= 6'd0;
         out_last_ff   <= 1'b0;
         case (cmd.out_sel)
            OUT_CPL: begin
               out_status_ff <= cmd.out_status;
            end
            OUT_RBYTE: begin
               out_rbyte_ff <= rbyte;
            end
            OUT_RREQ: begin
               out_kind_ff   <= RK_RREQ;
               out_sector_ff <= cmd.rreq_from_in ? in_sector : pend_sec_ff;
            end
            default: begin
               out_kind_ff   <= RK_WB;
               out_sector_ff <= cached_ff;
               out_word_ff   <= rd_word;
               out_index_ff  <= 6'(wb_cnt_ff);
               out_last_ff   <= (wb_cnt_ff == LAST_WORD);
            end
         endcase
      end
   end

   assign out_kind   = out_kind_ff;
   assign out_status = out_status_ff;
   assign out_rbyte  = out_rbyte_ff;
   assign out_sector = out_sector_ff;
   assign out_word   = out_word_ff;
   assign out_index  = out_index_ff;
   assign out_last   = out_last_ff;

   // status to the controller
   assign sts.hit      = (in_sector == cached_ff);
   assign sts.off_ok   = ({3'b000, in_offset} < SB_LIMIT);
   assign sts.needs_wb = dirty_ff && (cached_ff != 32'd0);
   assign sts.wb_last  = (wb_cnt_ff == LAST_WORD);
   assign sts.pend_req = pend_req_ff;

endmodule

`default_nettype wire

/* rtl/slsc_ctrl.sv */
// slsc_ctrl: controller state machine of the sector cache - request decode,
// media phases, write-back sequencing and result valid.
// Depends on slsc_pkg.
`default_nettype none

module slsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            in_kind,
   input  logic                  in_ok,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  slsc_pkg::slsc_sts_type sts,
   output slsc_pkg::slsc_cmd_type cmd
);
   import slsc_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_WAIT_WB   = 3'd1;
   localparam logic [2:0] S_WAIT_FILL = 3'd2;
   localparam logic [2:0] S_ACC       = 3'd3;
   localparam logic [2:0] S_WB_RD     = 3'd4;
   localparam logic [2:0] S_WB_LD     = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, accepting, acc;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign accepting  = (state_ff == S_IDLE) || (state_ff == S_WAIT_WB) ||
                       (state_ff == S_WAIT_FILL);
   assign req_tready = accepting && out_free;
   assign acc        = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // decode and sequencing
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (in_kind)
                  KIND_READ, KIND_WRITE: begin
                     if (!sts.off_ok) begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_sel    = OUT_CPL;
                        cmd.out_status = ST_INVAL;
                     end else begin
                        cmd.pend_ld     = 1'b1;
                        cmd.pend_req    = (in_kind == KIND_WRITE) ? PREQ_WRITE : PREQ_READ;
                        cmd.pend_sec_ld = 1'b1;
                        cmd.pend_acc_ld = 1'b1;
                        if (sts.hit) begin
                           cmd.rd_en  = 1'b1;
                           cmd.rd_sel = RD_IN;
                           state_in   = S_ACC;
                        end else if (sts.needs_wb) begin
                           cmd.wb_start = 1'b1;
                           state_in     = S_WB_RD;
                        end else begin
                           cmd.out_ld       = 1'b1;
                           cmd.out_sel      = OUT_RREQ;
                           cmd.rreq_from_in = 1'b1;
                           cmd.fill_clr     = 1'b1;
                           state_in         = S_WAIT_FILL;
                        end
                     end
                  end
                  KIND_ZERO: begin
                     cmd.pend_ld     = 1'b1;
                     cmd.pend_req    = PREQ_ZERO;
                     cmd.pend_sec_ld = 1'b1;
                     if (sts.needs_wb) begin
                        cmd.wb_start = 1'b1;
                        state_in     = S_WB_RD;
                     end else begin
                        cmd.zero_now     = 1'b1;
                        cmd.zero_from_in = 1'b1;
                        cmd.out_ld       = 1'b1;
                        cmd.out_sel      = OUT_CPL;
                        cmd.out_status   = ST_GOOD;
                     end
                  end
                  KIND_FLUSH: begin
                     cmd.pend_ld  = 1'b1;
                     cmd.pend_req = PREQ_FLUSH;
                     if (sts.needs_wb) begin
                        cmd.wb_start = 1'b1;
                        state_in     = S_WB_RD;
                     end else begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_sel    = OUT_CPL;
                        cmd.out_status = ST_GOOD;
                     end
                  end
                  default: begin
                     // stray media items are dropped
                  end
               endcase
            end
         end
         S_WAIT_WB: begin
            if (acc && (in_kind == KIND_ACK)) begin
               state_in = S_IDLE;
               if (!in_ok) begin
                  cmd.out_ld     = 1'b1;
                  cmd.out_sel    = OUT_CPL;
                  cmd.out_status = ST_WERR;
               end else begin
                  case (sts.pend_req)
                     PREQ_READ, PREQ_WRITE: begin
                        cmd.out_ld   = 1'b1;
                        cmd.out_sel  = OUT_RREQ;
                        cmd.fill_clr = 1'b1;
                        state_in     = S_WAIT_FILL;
                     end
                     PREQ_ZERO: begin
                        cmd.zero_now   = 1'b1;
                        cmd.out_ld     = 1'b1;
                        cmd.out_sel    = OUT_CPL;
                        cmd.out_status = ST_GOOD;
                     end
                     default: begin
                        cmd.out_ld     = 1'b1;
                        cmd.out_sel    = OUT_CPL;
                        cmd.out_status = ST_GOOD;
                     end
                  endcase
               end
            end
         end
         S_WAIT_FILL: begin
            if (acc && (in_kind == KIND_FILL)) begin
               cmd.fill_wr = 1'b1;
            end else if (acc && (in_kind == KIND_ACK)) begin
               if (!in_ok) begin
                  cmd.out_ld     = 1'b1;
                  cmd.out_sel    = OUT_CPL;
                  cmd.out_status = ST_RERR;
                  state_in       = S_IDLE;
               end else begin
                  cmd.commit_fill = 1'b1;
                  cmd.rd_en       = 1'b1;
                  cmd.rd_sel      = RD_PEND;
                  state_in        = S_ACC;
               end
            end
         end
         S_ACC: begin
            // buffer word is back: merge a write or return a byte
            cmd.out_ld = 1'b1;
            if (sts.pend_req == PREQ_WRITE) begin
               cmd.acc_wr     = 1'b1;
               cmd.out_sel    = OUT_CPL;
               cmd.out_status = ST_GOOD;
            end else begin
               cmd.out_sel = OUT_RBYTE;
            end
            state_in = S_IDLE;
         end
         S_WB_RD: begin
            if (out_free) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_WB;
               state_in   = S_WB_LD;
            end
         end
         S_WB_LD: begin
            cmd.out_ld  = 1'b1;
            cmd.out_sel = OUT_WB;
            if (sts.wb_last) begin
               state_in = S_WAIT_WB;
            end else begin
               cmd.wb_inc = 1'b1;
               state_in   = S_WB_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/single_line_sector_cache.sv */
// single_line_sector_cache: one-sector write-back cache in front of block media.
// Completions and read requests appear in the cycle after the item is accepted;
// a hit read or write passes a buffer read, then the result register. Write-back
// streams SECTOR_BYTES/8 words, each a buffer read and then a result load, waiting
// while a result is held; fill words are written as accepted. Reset is synchronous:
// sector 0 cached, clean, all-zero. Depends on slsc_pkg, slsc_ctrl, slsc_dp.
`default_nettype none

module single_line_sector_cache (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sector[31:0], byte_offset[41:32], write_byte[49:42], fill_word[113:50],
   // media_ok[114], zero pad[119:115]
   input  logic [slsc_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], read_byte[9:2], media_sector[41:10], media_word[105:42],
   // word_index[111:106]
   output logic [slsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   import slsc_pkg::*;

   slsc_cmd_type cmd;
   slsc_sts_type sts;
   logic [1:0]   out_status;
   logic [7:0]   out_rbyte;
   logic [31:0]  out_sector;
   logic [63:0]  out_word;
   logic [5:0]   out_index;

   // controller
   slsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .in_kind    (req_tuser),
      .in_ok      (req_tdata[114]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath
   slsc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_sector  (req_tdata[31:0]),
      .in_offset  (req_tdata[41:32]),
      .in_byte    (req_tdata[49:42]),
      .in_fill    (req_tdata[113:50]),
      .out_kind   (rsp_tuser),
      .out_status (out_status),
      .out_rbyte  (out_rbyte),
      .out_sector (out_sector),
      .out_word   (out_word),
      .out_index  (out_index),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {out_index, out_word, out_sector, out_rbyte, out_status};

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // starting a write-back leaves the buffer clean
   a_wb_cleans: assert property (@(posedge clock) disable iff (reset)
      cmd.wb_start |=> !sts.needs_wb)
      else $error("buffer still dirty after write-back start");

   // tlast only marks write-back words
   a_last_wb: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == RK_WB))
      else $error("tlast on a non write-back item");

   // no item is taken while write-back words are being sequenced
   a_no_accept_in_wb: assert property (@(posedge clock) disable iff (reset)
      cmd.wb_inc |-> !req_tready)
      else $error("item accepted during write-back");

endmodule

`default_nettype wire

/* test/single_line_sector_cache_tb.sv */
// single_line_sector_cache_tb: self-checking bench for the one-sector write-back cache.
// Predicts every response from a behavioral copy of the cache line and drives both
// stream sides with random gaps. Depends on slsc_pkg and single_line_sector_cache.
`timescale 1ns / 1ps

module single_line_sector_cache_tb;
   import slsc_pkg::*;

   localparam int LINE_WORDS   = SECTOR_BYTES / 8;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2 * LINE_WORDS + 20;
   localparam int RANDOM_ITEMS = 180;

   typedef enum logic [1:0] {LINE_IDLE, LINE_WRITEBACK, LINE_FILL} line_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  rbyte;
      logic [31:0] msector;
      logic [63:0] mword;
      logic [5:0]  widx;
      logic        last;
   } cache_rsp_type;

   // behavioral copy of the cache line and the responses it still owes
   class sector_cache_scoreboard;
      logic [63:0]    line_words[LINE_WORDS];
      logic [31:0]    line_sector;
      logic           line_dirty;
      logic           line_zero;
      line_phase_type phase;
      logic [1:0]     pend_req;
      logic [31:0]    pend_sector;
      logic [8:0]     pend_offset;
      logic [7:0]     pend_byte;
      logic [5:0]     fill_ptr;
      cache_rsp_type  awaited[$];
      int             errors;
      int             n_requests;
      int             n_wb_words;
      int             n_media_reads;
      int             n_status[4];

      function new();
         foreach (line_words[i]) line_words[i] = '0;
         line_sector = '0;
         line_dirty  = 1'b0;
         line_zero   = 1'b0;
         phase       = LINE_IDLE;
         pend_req    = PREQ_READ;
         pend_sector = '0;
         pend_offset = '0;
         pend_byte   = '0;
         fill_ptr    = '0;
         errors      = 0;
         n_requests  = 0;
         n_wb_words  = 0;
         n_media_reads = 0;
         foreach (n_status[i]) n_status[i] = 0;
      endfunction

      function void owe(logic [1:0] kind, logic [1:0] status, logic [7:0] rbyte,
                        logic [31:0] msector, logic [63:0] mword, logic [5:0] widx,
                        logic last);
         cache_rsp_type r;
         r = '{kind, status, rbyte, msector, mword, widx, last};
         awaited.push_back(r);
      endfunction

      function void finish_req(logic [1:0] status);
         phase = LINE_IDLE;
         owe(RK_CPL, status, 8'd0, 32'd0, 64'd0, 6'd0, 1'b0);
      endfunction

      // whole line goes out at once, then the ack is awaited
      function void write_back();
         line_dirty = 1'b0;
         for (int i = 0; i < LINE_WORDS; i++)
            owe(RK_WB, ST_GOOD, 8'd0, line_sector, line_words[i], i[5:0],
                i == LINE_WORDS - 1);
         phase = LINE_WRITEBACK;
      endfunction

      function void issue_read();
         owe(RK_RREQ, ST_GOOD, 8'd0, pend_sector, 64'd0, 6'd0, 1'b0);
         fill_ptr = '0;
         phase    = LINE_FILL;
      endfunction

      function void zero_line();
         foreach (line_words[i]) line_words[i] = '0;
         line_sector = pend_sector;
         line_dirty  = 1'b1;
         line_zero   = 1'b1;
         owe(RK_CPL, ST_GOOD, 8'd0, 32'd0, 64'd0, 6'd0, 1'b0);
      endfunction

      // byte read or byte write on the cached line
      function void access_line();
         logic [5:0] w;
         logic [5:0] sh;
         logic [7:0] rb;
         w  = pend_offset[8:3];
         sh = {pend_offset[2:0], 3'b000};
         rb = 8'd0;
         if (pend_req == PREQ_WRITE) begin
            line_words[w][sh +: 8] = pend_byte;
            line_dirty = 1'b1;
            line_zero  = 1'b0;
         end else begin
            rb = line_words[w][sh +: 8];
         end
         owe(RK_CPL, ST_GOOD, rb, 32'd0, 64'd0, 6'd0, 1'b0);
      endfunction

      function bit must_write_back();
         return line_dirty && line_sector != 32'd0;
      endfunction

      function void accept_request(logic [2:0] kind, logic [31:0] sec, logic [9:0] off,
                                   logic [7:0] wbyte, logic [63:0] fword, logic ok);
         n_requests++;
         case (phase)
            LINE_WRITEBACK: begin
               if (kind != KIND_ACK) return;
               if (!ok) begin
                  finish_req(ST_WERR);
                  return;
               end
               phase = LINE_IDLE;
               if (pend_req == PREQ_READ || pend_req == PREQ_WRITE) issue_read();
               else if (pend_req == PREQ_ZERO) zero_line();
               else finish_req(ST_GOOD);
            end
            LINE_FILL: begin
               if (kind == KIND_FILL) begin
                  // extra words wrap around to word 0
                  line_words[fill_ptr] = fword;
                  fill_ptr  = fill_ptr + 6'd1;
                  line_zero = 1'b0;
                  return;
               end
               if (kind != KIND_ACK) return;
               phase = LINE_IDLE;
               if (!ok) begin
                  finish_req(ST_RERR);
                  return;
               end
               line_sector = pend_sector;
               line_dirty  = 1'b0;
               line_zero   = 1'b0;
               access_line();
            end
            default: begin
               phase = LINE_IDLE;
               if (kind == KIND_READ || kind == KIND_WRITE) begin
                  if (off >= SECTOR_BYTES) begin
                     finish_req(ST_INVAL);
                     return;
                  end
                  pend_req    = kind[1:0];
                  pend_sector = sec;
                  pend_offset = off[8:0];
                  pend_byte   = wbyte;
                  if (sec == line_sector) access_line();
                  else if (must_write_back()) write_back();
                  else issue_read();
               end else if (kind == KIND_ZERO) begin
                  pend_req    = PREQ_ZERO;
                  pend_sector = sec;
                  if (must_write_back()) write_back();
                  else zero_line();
               end else if (kind == KIND_FLUSH) begin
                  pend_req = PREQ_FLUSH;
                  if (must_write_back()) write_back();
                  else finish_req(ST_GOOD);
               end
            end
         endcase
      endfunction

      function void check_response(cache_rsp_type got);
         cache_rsp_type want;
         if (awaited.size() == 0) begin
            $error("response with none awaited: kind %0d sector %0h", got.kind,
                   got.msector);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.kind === RK_WB) n_wb_words++;
         if (got.kind === RK_RREQ) n_media_reads++;
         if (got.kind === RK_CPL) n_status[got.status]++;
         if (got.kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.rbyte !== want.rbyte) begin
            $error("read_byte: expected %0h, got %0h", want.rbyte, got.rbyte);
            errors++;
         end
         if (got.msector !== want.msector) begin
            $error("media_sector: expected %0h, got %0h", want.msector, got.msector);
            errors++;
         end
         if (got.mword !== want.mword) begin
            $error("media_word: expected %0h, got %0h", want.mword, got.mword);
            errors++;
         end
         if (got.widx !== want.widx) begin
            $error("word_index: expected %0d, got %0d", want.widx, got.widx);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = KIND_READ;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   logic steady = 1'b0;
   logic hold_start_req = 1'b0;
   bit   hold_started = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   sector_cache_scoreboard sb = new();

   single_line_sector_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // response side: random back-pressure, one long hold-off, checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response('{rsp_tuser, rsp_tdata[1:0], rsp_tdata[9:2],
                                rsp_tdata[41:10], rsp_tdata[105:42],
                                rsp_tdata[111:106], rsp_tlast});
         if (hold_start_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 35);
         end
      end
   end

   // watchdog on cycles with no item moving either way
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d responses outstanding",
                     quiet_cycles, sb.awaited.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // offer one item, with random gaps ahead of it, and note it once taken
   task automatic send(input logic [2:0] kind, input logic [31:0] sec,
                       input logic [9:0] off, input logic [7:0] wbyte,
                       input logic [63:0] fword, input logic ok);
      while (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, ok, fword, wbyte, off, sec};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.accept_request(kind, sec, off, wbyte, fword, ok);
   endtask

   task automatic run_directed();
      // reset line is sector 0, all zero
      send(KIND_READ, 32'd0, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_READ, 32'd0, 10'd511, 8'd0, 64'd0, 1'b0);
      // offsets past the sector
      send(KIND_READ, 32'd0, 10'd512, 8'd0, 64'd0, 1'b0);
      send(KIND_WRITE, 32'hFFFF_FFFF, 10'd1023, 8'hFF, 64'd0, 1'b1);
      // dirty sector 0 is never written back
      send(KIND_WRITE, 32'd0, 10'd7, 8'hFF, 64'd0, 1'b0);
      send(KIND_FLUSH, 32'd0, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_READ, 32'd0, 10'd7, 8'd0, 64'd0, 1'b0);
      // zero out lands without write-back, then a hit write
      send(KIND_ZERO, 32'd5, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_WRITE, 32'd5, 10'd100, 8'hA5, 64'd0, 1'b0);
      // stray media items while idle
      send(KIND_FILL, 32'd0, 10'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send(KIND_ACK, 32'd0, 10'd0, 8'd0, 64'd0, 1'b1);
      // dirty miss: write-back under a long receiver stall
      send(KIND_READ, 32'hFFFF_FFFF, 10'd3, 8'd0, 64'd0, 1'b0);
      hold_start_req <= 1'b1;
      send(KIND_READ, 32'd9, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_ACK, 32'd0, 10'd0, 8'd0, 64'd0, 1'b1);
      // short fill, a request dropped while busy, then the ack
      send(KIND_FILL, 32'd0, 10'd0, 8'd0, 64'h8877_6655_4433_2211, 1'b0);
      send(KIND_FILL, 32'd0, 10'd0, 8'd0, 64'h0123_4567_89AB_CDEF, 1'b0);
      send(KIND_FLUSH, 32'd0, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_ACK, 32'd0, 10'd0, 8'd0, 64'd0, 1'b1);
      // failed write-back ack, then the line is clean
      send(KIND_WRITE, 32'hFFFF_FFFF, 10'd0, 8'h00, 64'd0, 1'b0);
      send(KIND_FLUSH, 32'd0, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_ACK, 32'd0, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_FLUSH, 32'd0, 10'd0, 8'd0, 64'd0, 1'b0);
      // failed fill ack
      send(KIND_READ, 32'd7, 10'd0, 8'd0, 64'd0, 1'b0);
      send(KIND_ACK, 32'd0, 10'd0, 8'd0, 64'd0, 1'b0);
   endtask

   // mostly well-formed media exchanges with random content, some noise
   task automatic run_random();
      int          taken;
      int          fills_left;
      int          r;
      bit          was_fill;
      logic [2:0]  kind;
      logic [31:0] sec;
      logic [9:0]  off;
      bit          counts;
      taken      = 0;
      fills_left = 0;
      while (taken < RANDOM_ITEMS) begin
         steady <= (taken >= 90 && taken < 140);
         r      = $urandom_range(99);
         counts = 1'b1;
         off    = 10'($urandom_range(0, SECTOR_BYTES - 1));
         sec    = $urandom;
         case (sb.phase)
            LINE_WRITEBACK: begin
               if (r < 8) begin
                  kind   = 3'($urandom_range(0, 3));
                  counts = 1'b0;
               end else begin
                  kind = KIND_ACK;
               end
            end
            LINE_FILL: begin
               if (r < 6) begin
                  kind   = 3'($urandom_range(0, 3));
                  counts = 1'b0;
               end else if (fills_left > 0) begin
                  kind = KIND_FILL;
                  fills_left--;
               end else begin
                  kind = KIND_ACK;
               end
            end
            default: begin
               if (r < 36) kind = KIND_READ;
               else if (r < 70) kind = KIND_WRITE;
               else if (r < 78) kind = KIND_ZERO;
               else if (r < 88) kind = KIND_FLUSH;
               else if (r < 94) kind = KIND_FILL;
               else kind = KIND_ACK;
               counts = (kind <= KIND_FLUSH);
               // keep most accesses on a few sectors so hits and misses mix
               r = $urandom_range(99);
               if (r < 45) sec = sb.line_sector;
               else if (r < 55) sec = 32'd0;
               else if (r < 80) sec = $urandom_range(1, 3);
               else if (r < 88) sec = 32'hFFFF_FFFF - $urandom_range(0, 1);
               r = $urandom_range(99);
               if (r < 8) off = 10'($urandom_range(SECTOR_BYTES, 1023));
               else if (r < 14) off = ($urandom_range(1) != 0) ? 10'd511 : 10'd0;
            end
         endcase
         was_fill = (sb.phase == LINE_FILL);
         send(kind, sec, off, 8'($urandom), {$urandom, $urandom},
              $urandom_range(99) >= 12);
         if (!was_fill && sb.phase == LINE_FILL) begin
            // short, whole or wrapping fill
            r = $urandom_range(99);
            if (r < 55) fills_left = $urandom_range(0, 6);
            else if (r < 85) fills_left = LINE_WORDS;
            else fills_left = $urandom_range(LINE_WORDS + 1, LINE_WORDS + 8);
         end
         if (counts) taken++;
      end
      steady <= 1'b0;
   endtask

   // reset, stimulus, drain, verdict
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items in, %0d write-back words, %0d media read requests",
               sb.n_requests, sb.n_wb_words, sb.n_media_reads);
      $display("completions: %0d good, %0d write error, %0d read error, %0d invalid",
               sb.n_status[ST_GOOD], sb.n_status[ST_WERR], sb.n_status[ST_RERR],
               sb.n_status[ST_INVAL]);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/slsc_pkg.sv
rtl/slsc_dp.sv
rtl/slsc_ctrl.sv
rtl/single_line_sector_cache.sv
test/single_line_sector_cache_tb.sv
